// File: hw/rtl/cdt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and interface structs for the CDT noise sampler.
// Used by cdt_search, cdt_noise_sampler and cdt_chk; depends on nothing else.
package cdt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int WORD_W      = 64;
	localparam int SIZE_W      = 6;
	localparam int MODE_W      = 2;
	localparam int NOISE_W     = 6;
	localparam int CFG_DATA_W  = 6;
	localparam int CFG_IDX_W   = 1;

	// Stream payload widths, padded to whole bytes.
	localparam int S_TDATA_W = 136;
	localparam int M_TDATA_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE = 1'b1;

	// Operating modes; the unused fourth code behaves as binary.
	localparam logic [MODE_W-1:0] MODE_GAUSS   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TERNARY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BINARY  = 2'd2;

	// Request kinds carried on tuser.
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_LOAD   = 1'b1;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  index;
		logic [WORD_W-1:0] data;
	} load_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] rnd_word;
		logic [SIZE_W-1:0] count;
	} search_req_t;

	typedef struct packed {
		logic             done;
		logic             hit;
		logic [IDX_W-1:0] index;
	} search_rsp_t;

endpackage

// File: hw/rtl/cdt_noise_sampler.sv
`timescale 1ns / 1ps
// Top level of the CDT noise sampler: stream handshake, mode decode, output register.
// Depends on cdt_pkg and instantiates cdt_search.

// The sampler takes one request at a time on the slave stream. A load request
// (tuser high) writes one 64-bit threshold into the table and gives no result.
// A sample request returns one signed 6-bit noise value on the master stream,
// with tlast copied from the request. In ternary and binary mode a sample is
// decided in the cycle it is taken, and its result goes into the output register
// or, while that register is still occupied, into a hold register. In Gaussian
// mode the compare unit walks the table from entry zero, one entry per cycle
// through the registered memory read, and stops at the first threshold at or
// above the random word. A hit, or a miss after the last entry in use, passes
// from the compare into the response register and then into the output
// register; the block takes no new request until then, so the length of the
// table scan sets how long a Gaussian sample holds the block.
// The result index minus table_size / 2 is returned, or +table_size / 2 when no
// entry qualifies. All table_size entries in use must be loaded before sampling.
// The finished result sits in an output register, so the next request is taken
// while it waits; outside the Gaussian scan, requests are held off only while
// a second result waits in the hold register. Configuration writes go straight
// into the mode and table_size registers and are meant for idle periods only.
module cdt_noise_sampler (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [cdt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cdt_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Request stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata from bit 0: random_word[63:0], load_index[69:64],
	// threshold[133:70], zero padding[135:134].
	input  logic [cdt_pkg::S_TDATA_W-1:0]     s_tdata,
	// s_tuser: kind (0 sample, 1 load).
	input  logic                              s_tuser,
	input  logic                              s_tlast,
	// Result stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata from bit 0: noise_value[5:0] (signed), zero padding[7:6].
	output logic [cdt_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                              m_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]                     state_q;
	logic [1:0]                     state_d;
	logic [cdt_pkg::MODE_W-1:0]     mode_q;
	logic [cdt_pkg::SIZE_W-1:0]     size_q;
	logic                           last_q;
	logic [cdt_pkg::NOISE_W-1:0]    res_q;
	logic                           m_tvalid_q;
	logic [cdt_pkg::NOISE_W-1:0]    m_noise_q;
	logic                           m_last_q;

	logic [cdt_pkg::WORD_W-1:0]     rnd_word;
	logic                           accept;
	logic                           out_free;
	logic                           out_load;
	logic [cdt_pkg::NOISE_W-1:0]    out_noise;
	logic                           out_last;
	logic                           hold_load;
	logic [cdt_pkg::NOISE_W-1:0]    quick_noise;
	logic [cdt_pkg::NOISE_W-1:0]    gauss_noise;
	logic [cdt_pkg::NOISE_W-1:0]    centre;

	cdt_pkg::load_t       load;
	cdt_pkg::search_req_t req;
	cdt_pkg::search_rsp_t rsp;

	assign rnd_word = s_tdata[cdt_pkg::WORD_W-1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign load.we    = accept && (s_tuser == cdt_pkg::KIND_LOAD);
	assign load.index = s_tdata[cdt_pkg::WORD_W +: cdt_pkg::IDX_W];
	assign load.data  = s_tdata[cdt_pkg::WORD_W + cdt_pkg::IDX_W +: cdt_pkg::WORD_W];

	assign req.start    = accept && (s_tuser == cdt_pkg::KIND_SAMPLE)
		&& (mode_q == cdt_pkg::MODE_GAUSS);
	assign req.rnd_word = rnd_word;
	assign req.count    = size_q;

	cdt_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.req    (req),
		.rsp    (rsp)
	);

	// Ternary maps the two low bits to +1, -1, 0, 0; binary (and the unused
	// fourth mode) passes bit 0 through.
	always_comb begin
		case (mode_q)
			cdt_pkg::MODE_TERNARY: begin
				case (rnd_word[1:0])
					2'd0:    quick_noise = cdt_pkg::NOISE_W'(1);
					2'd1:    quick_noise = '1;
					default: quick_noise = '0;
				endcase
			end
			default: quick_noise = cdt_pkg::NOISE_W'(rnd_word[0]);
		endcase
	end

	// The center is half the entries in use; a miss returns +center.
	assign centre      = cdt_pkg::NOISE_W'(size_q >> 1);
	assign gauss_noise = rsp.hit ? (cdt_pkg::NOISE_W'(rsp.index) - centre) : centre;

	always_comb begin
		state_d   = state_q;
		out_load  = 1'b0;
		out_noise = res_q;
		out_last  = last_q;
		hold_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.start) begin
					state_d = ST_SCAN;
				end else if (accept && (s_tuser == cdt_pkg::KIND_SAMPLE)) begin
					out_noise = quick_noise;
					out_last  = s_tlast;
					if (out_free) begin
						out_load = 1'b1;
					end else begin
						hold_load = 1'b1;
						state_d   = ST_HOLD;
					end
				end
			end
			ST_SCAN: begin
				if (rsp.done) begin
					out_noise = gauss_noise;
					if (out_free) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						hold_load = 1'b1;
						state_d   = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (hold_load) begin
			res_q <= out_noise;
			last_q <= out_last;
		end else if (accept) begin
			last_q <= s_tlast;
		end
		if (out_load) begin
			m_noise_q <= out_noise;
			m_last_q  <= out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= cdt_pkg::MODE_GAUSS;
			size_q     <= cdt_pkg::SIZE_W'(1);
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					cdt_pkg::REG_MODE: mode_q <= cfg_data[cdt_pkg::MODE_W-1:0];
					cdt_pkg::REG_SIZE: size_q <= cfg_data[cdt_pkg::SIZE_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = cdt_pkg::M_TDATA_W'(m_noise_q);
	assign m_tlast  = m_last_q;

endmodule

// File: hw/rtl/cdt_search.sv
`timescale 1ns / 1ps
// Threshold memory and the sequential compare unit that scans it.
// Depends on cdt_pkg for widths and the load/request/response structs.
module cdt_search (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cdt_pkg::load_t       load,
	input  cdt_pkg::search_req_t req,
	output cdt_pkg::search_rsp_t rsp
);

	logic [cdt_pkg::WORD_W-1:0] mem [cdt_pkg::TABLE_DEPTH];

	logic                        busy_q;
	logic [cdt_pkg::IDX_W-1:0]   ptr_q;
	logic [cdt_pkg::SIZE_W-1:0]  cnt_q;
	logic [cdt_pkg::WORD_W-1:0]  rnd_q;
	logic                        cmp_vld_s1;
	logic [cdt_pkg::IDX_W-1:0]   idx_s1;
	logic [cdt_pkg::WORD_W-1:0]  rd_s1;
	logic                        done_q;
	logic                        hit_q;
	logic [cdt_pkg::IDX_W-1:0]   index_q;

	logic issue;
	logic cmp_hit;
	logic cmp_end;

	assign issue   = busy_q && (cdt_pkg::SIZE_W'(ptr_q) < cnt_q);
	assign cmp_hit = cmp_vld_s1 && (rnd_q <= rd_s1);
	assign cmp_end = cmp_vld_s1 && (cdt_pkg::SIZE_W'(idx_s1) == cnt_q - cdt_pkg::SIZE_W'(1));

	// One write port for loads, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (load.we) begin
			mem[load.index] <= load.data;
		end
		rd_s1 <= mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rnd_q <= req.rnd_word;
			cnt_q <= req.count;
		end
		idx_s1 <= ptr_q;
		if (cmp_hit) begin
			index_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			ptr_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				ptr_q      <= '0;
				cmp_vld_s1 <= 1'b0;
				hit_q      <= 1'b0;
				// An empty table finishes at once with no hit.
				busy_q     <= (req.count != '0);
				done_q     <= (req.count == '0);
			end else if (busy_q) begin
				cmp_vld_s1 <= issue;
				if (issue) begin
					ptr_q <= ptr_q + cdt_pkg::IDX_W'(1);
				end
				if (cmp_hit || cmp_end) begin
					busy_q     <= 1'b0;
					cmp_vld_s1 <= 1'b0;
					done_q     <= 1'b1;
					hit_q      <= cmp_hit;
				end
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.hit   = hit_q;
	assign rsp.index = index_q;

endmodule

// File: hw/rtl/cdt_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the CDT noise sampler, bound to the top level.
// Depends on cdt_pkg and on the port list of cdt_noise_sampler.
module cdt_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [cdt_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic                           m_tlast
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// A load request leaves the block ready in the following cycle.
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == cdt_pkg::KIND_LOAD) |=> s_tready)
		else $error("block not ready after a load request");

	// After a sample request either a result is shown or the block is busy.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == cdt_pkg::KIND_SAMPLE) |=> !s_tready || m_tvalid)
		else $error("sample request neither busy nor answered");

	// Noise stays within -31..31 and the padding bits stay zero.
	a_noise_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:0] != 6'b100000) && (m_tdata[7:6] == 2'b00))
		else $error("noise value out of range");

endmodule

bind cdt_noise_sampler cdt_chk u_cdt_chk (.*);

// File: sim/tb_cdt_noise_sampler.sv
`timescale 1ns / 1ps
// Self-checking testbench for cdt_noise_sampler: fills the threshold table, draws Gaussian,
// ternary and binary noise, and compares every result with a local noise predictor.
// Depends on cdt_pkg and the cdt_noise_sampler RTL; reads no files.
module tb_cdt_noise_sampler;
	import cdt_pkg::*;

	// This exceeds the longest Gaussian scan, so it covers any request still in
	// flight when the last expected result has arrived.
	localparam int SETTLE_CYCLES = 80;
	// Length of the long receiver hold-off that backs the block up.
	localparam int HOLD_CYCLES = 300;
	// The fourth mode code has no package name; the block decodes it as binary.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// One expected result, in the order the requests were accepted.
	typedef struct packed {
		logic [NOISE_W-1:0] noise;
		logic               last;
	} noise_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	// s_tdata from bit 0: random_word, load_index, threshold, zero padding.
	logic [S_TDATA_W-1:0]  s_tdata;
	// s_tuser: kind (sample or load).
	logic                  s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	// m_tdata from bit 0: noise_value (signed), zero padding.
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tlast;

	// Predictor state: its own copy of the table and of both registers.
	logic [WORD_W-1:0] cdt_table [TABLE_DEPTH];
	logic [MODE_W-1:0] mode_q;
	logic [SIZE_W-1:0] size_q;
	noise_result_t     noise_due [$];

	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	int rx_hold = 0;
	int mismatches = 0;

	cdt_noise_sampler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Noise for one random word under the current mode and table. The scan runs
	// from the top entry down so the lowest qualifying index is the one kept; when
	// nothing qualifies the value stays at +center. table_size is six bits wide and
	// can never exceed the table depth, so no clamp is needed.
	function automatic logic [NOISE_W-1:0] predict_noise(input logic [WORD_W-1:0] rnd);
		int n;
		int centre;
		int v;
		n = int'(size_q);
		centre = n / 2;
		v = centre;
		if (mode_q == MODE_GAUSS) begin
			for (int i = n - 1; i >= 0; i--)
				if (rnd <= cdt_table[i])
					v = i - centre;
		end else if (mode_q == MODE_TERNARY) begin
			case (rnd[1:0])
				2'd0: v = 1;
				2'd1: v = -1;
				default: v = 0;
			endcase
		end else begin
			v = int'(rnd[0]);
		end
		return v[NOISE_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// In Gaussian mode half the words land on or right beside a threshold in use,
	// which is where an off-by-one in the compare would show.
	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] t;
		if (mode_q != MODE_GAUSS || size_q == 0 || $urandom_range(0, 1) == 0)
			return rand_word();
		t = cdt_table[$urandom_range(0, size_q - 1)];
		case ($urandom_range(0, 2))
			0: return t - 1;
			1: return t;
			default: return t + 1;
		endcase
	endfunction

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: %s", $time, msg);
	endtask

	// Offers one request and returns in the time step it is accepted, with
	// s_tvalid still high. The caller either sends the next request at once or
	// drops s_tvalid, so the line never gets two updates in one step.
	task automatic send_request(input logic kind, input logic [WORD_W-1:0] rnd,
			input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] thr, input logic last);
		int gap;
		noise_result_t item;
		gap = tx_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tlast  <= last;
		s_tdata  <= {2'b00, thr, idx, rnd};
		do @(posedge clk); while (!s_tready);
		if (kind == KIND_LOAD) begin
			cdt_table[idx] = thr;
		end else begin
			item.noise = predict_noise(rnd);
			item.last  = last;
			noise_due  = {noise_due, item};
		end
	endtask

	// A sample request; the load fields ride along with random contents.
	task automatic send_draw(input logic [WORD_W-1:0] rnd, input logic last);
		send_request(KIND_SAMPLE, rnd, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
			rand_word(), last);
	endtask

	task automatic release_stream();
		s_tvalid <= 1'b0;
	endtask

	task automatic drain_results();
		while (noise_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle_block();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both registers are written back to back, only once the block is idle.
	task automatic set_config(input logic [MODE_W-1:0] mode, input logic [SIZE_W-1:0] size);
		release_stream();
		settle_block();
		cfg_we    <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_data  <= CFG_DATA_W'(mode);
		@(posedge clk);
		mode_q = mode;
		cfg_index <= REG_SIZE;
		cfg_data  <= size;
		@(posedge clk);
		size_q = size;
		cfg_we <= 1'b0;
	endtask

	// Loads a well-formed cumulative table into entries 0 .. count-1. Steps stay
	// below 2^57 so the sum never wraps; the last entry sometimes reaches 1.0.
	task automatic load_cdt(input int count);
		logic [WORD_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < count; i++) begin
			acc = acc + (rand_word() >> 7);
			if (i == count - 1 && $urandom_range(0, 1) == 1)
				acc = '1;
			send_request(KIND_LOAD, rand_word(), i[IDX_W-1:0], acc, 1'($urandom_range(0, 1)));
		end
	endtask

	// Every entry is written before any Gaussian request can read it.
	task automatic test_table_fill();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		load_cdt(TABLE_DEPTH);
	endtask

	// Largest table: lowest and highest words, words on and beside thresholds,
	// a word above every entry in use, and threshold extremes at both ends.
	task automatic test_gauss_edges();
		set_config(MODE_GAUSS, 6'd63);
		send_draw('0, 1'b0);
		send_draw('1, 1'b1);
		send_draw(cdt_table[62], 1'b0);
		send_draw(cdt_table[30], 1'b0);
		send_draw(cdt_table[30] + 1, 1'b0);
		send_draw(cdt_table[31], 1'b1);
		send_request(KIND_LOAD, rand_word(), 6'd0, '0, 1'b0);
		send_draw('0, 1'b0);
		send_draw(64'd1, 1'b0);
		send_request(KIND_LOAD, rand_word(), 6'd63, '1, 1'b1);
		send_request(KIND_LOAD, rand_word(), 6'd62, '1, 1'b0);
		send_draw('1, 1'b1);
	endtask

	// One entry has center zero; a size of zero has no entry and gives zero too.
	task automatic test_small_tables();
		set_config(MODE_GAUSS, 6'd1);
		send_draw('0, 1'b0);
		send_draw(rand_word(), 1'b1);
		set_config(MODE_GAUSS, 6'd0);
		send_draw(rand_word(), 1'b1);
	endtask

	task automatic test_ternary();
		logic [WORD_W-1:0] w;
		set_config(MODE_TERNARY, 6'd5);
		for (int t = 0; t < 4; t++) begin
			w = rand_word();
			w[1:0] = t[1:0];
			send_draw(w, t == 3);
		end
	endtask

	// Binary mode and the unused fourth code, which must behave the same.
	task automatic test_binary();
		set_config(MODE_BINARY, 6'd9);
		send_draw(rand_word() & ~64'd1, 1'b0);
		send_draw('1, 1'b1);
		set_config(MODE_UNUSED, 6'd9);
		send_draw(rand_word() & ~64'd1, 1'b1);
		send_draw(rand_word() | 64'd1, 1'b0);
	endtask

	// The receiver stops for a long stretch while requests keep coming, so the
	// output register fills and the block has to hold off its input.
	task automatic test_output_stall();
		set_config(MODE_GAUSS, 6'd15);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold = HOLD_CYCLES;
		repeat (30) send_draw(pick_word(), 1'($urandom_range(0, 1)));
	endtask

	// The sender goes quiet until every result is back, then resumes.
	task automatic test_sender_pause();
		set_config(MODE_GAUSS, 6'd7);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (8) send_draw(pick_word(), 1'($urandom_range(0, 1)));
		release_stream();
		drain_results();
		repeat (8) send_draw(pick_word(), 1'($urandom_range(0, 1)));
	endtask

	// Random phases: mostly small odd tables, now and then the extremes, often a
	// fresh well-formed table, and a sprinkling of stray loads into any entry.
	task automatic test_random();
		logic [MODE_W-1:0] mode;
		logic [SIZE_W-1:0] size;
		int roll;
		repeat (8) begin
			roll = $urandom_range(0, 19);
			mode = MODE_W'($urandom_range(0, 3));
			if (roll == 0)
				size = '0;
			else if (roll < 3)
				size = 6'd63;
			else if (roll < 5)
				size = SIZE_W'($urandom_range(0, 63));
			else
				size = SIZE_W'(2 * $urandom_range(0, 7) + 1);
			set_config(mode, size);
			tx_idle = $urandom_range(0, 2) != 0;
			rx_idle = $urandom_range(0, 2) != 0;
			if (mode == MODE_GAUSS && $urandom_range(0, 1) == 1)
				load_cdt(size);
			repeat (30) begin
				if ($urandom_range(0, 9) == 0)
					send_request(KIND_LOAD, rand_word(),
						IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), rand_word(),
						1'($urandom_range(0, 1)));
				else
					send_draw(pick_word(), $urandom_range(0, 7) == 0);
			end
		end
	endtask

	initial begin : stimulus
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= KIND_SAMPLE;
		s_tlast   <= 1'b0;
		mode_q = MODE_GAUSS;
		size_q = 6'd1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_fill();
		test_gauss_edges();
		test_small_tables();
		test_ternary();
		test_binary();
		test_output_stall();
		test_sender_pause();
		test_random();

		release_stream();
		settle_block();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Result side: draws a stall before each result, takes a pending long hold-off
	// when one is asked for, and checks every accepted result against the oldest
	// expectation.
	initial begin : result_sink
		noise_result_t due;
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_idle ? $urandom_range(0, 3) : 0;
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (noise_due.size() == 0) begin
				log_mismatch($sformatf("unexpected result: noise %0d last %b",
					$signed(m_tdata[NOISE_W-1:0]), m_tlast));
			end else begin
				due = noise_due.pop_front();
				if (m_tdata[NOISE_W-1:0] !== due.noise || m_tlast !== due.last)
					log_mismatch($sformatf(
						"result mismatch: expected noise %0d last %b, got noise %0d last %b",
						$signed(due.noise), due.last, $signed(m_tdata[NOISE_W-1:0]),
						m_tlast));
			end
		end
	end

	// Hard stop well past the slowest correct run.
	initial begin : watchdog
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
